>>> hdl/pss_pkg.sv
package pss_pkg;

    // request codes on the input channel
    typedef enum logic [1:0] {
        REQ_NEEDLE = 2'd0,
        REQ_HAY    = 2'd1,
        REQ_SEARCH = 2'd2
    } t_req;

    typedef logic [7:0] t_byte;
    typedef logic [7:0] t_off;
    typedef logic [8:0] t_len;

    localparam t_byte SEP_SLASH  = 8'h2F;
    localparam t_byte SEP_BSLASH = 8'h5C;
    localparam t_byte CHR_UP_A   = 8'h41;
    localparam t_byte CHR_UP_Z   = 8'h5A;
    localparam t_byte CASE_BIT   = 8'h20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_EVAL,
        ST_SKIP_RD,
        ST_SKIP_EV,
        ST_HIT,
        ST_MISS
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic app_needle;
        logic app_hay;
        logic init;
        logic next_start;
        logic pair_step;
        logic skip_enter;
        logic skip_step;
        logic load_hit;
        logic load_miss;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic needle_empty;
        logic hay_empty;
        logic in_range;
        logic needle_done;
        logic pair_sep;
        logic pair_eq;
        logic has_next;
        logic skip_more;
        logic out_free;
    } t_stat;

    function automatic logic is_sep(input t_byte b);
        return (b == SEP_SLASH) || (b == SEP_BSLASH);
    endfunction

    function automatic t_byte fold_case(input t_byte b);
        if (b inside {[CHR_UP_A:CHR_UP_Z]}) begin
            return b | CASE_BIT;
        end
        return b;
    endfunction

endpackage

>>> hdl/pss_ifs.sv
interface pss_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] char_byte;

    modport source (output valid, output req_type, output char_byte, input ready);
    modport sink   (input valid, input req_type, input char_byte, output ready);
endinterface

interface pss_res_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] match_offset;
    logic [8:0] match_length;
    logic       overflow;

    modport source (output valid, output found, output match_offset,
                    output match_length, output overflow, input ready);
    modport sink   (input valid, input found, input match_offset,
                    input match_length, input overflow, output ready);
endinterface

>>> hdl/path_substring_search_core.sv
// channel   | dir | payload                                      | handshake
// ----------+-----+----------------------------------------------+-----------
// i_req     | in  | req_type[1:0], char_byte[7:0]                | valid/ready
// o_res     | out | found, match_offset[7:0], match_length[8:0], | valid/ready
//           |     | overflow                                     |
//
// appends are accepted back to back while the controller is idle
// a search walks the two stores through their single read ports: each
// compare or separator-run step has a read state, then a compare state
// (ST_STEP then ST_EVAL, ST_SKIP_RD then ST_SKIP_EV), and long separator
// runs are walked again from every start position
// synchronous active-low reset clears the counts, drop flag, scan pointers,
// result valid and controller; store contents are left as they are, only entries below the counts are read
// appends keep flowing while a result waits; a finished search holds until
// the result register is free
module path_substring_search_core #(
    parameter int NEEDLE_DEPTH   = 64,
    parameter int HAYSTACK_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pss_req_if.sink   i_req,
    pss_res_if.source o_res
);

    pss_pkg::t_cmd  w_cmd;
    pss_pkg::t_stat w_stat;
    logic           w_ready;

    // controller: sequences appends, start positions, compare and skip steps
    pss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .i_req_type (i_req.req_type),
        .o_ready    (w_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    assign i_req.ready = w_ready;

    // datapath: byte stores, scan pointers, comparators and result register
    pss_dp #(
        .NEEDLE_DEPTH   (NEEDLE_DEPTH),
        .HAYSTACK_DEPTH (HAYSTACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_byte (i_req.char_byte),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_res       (o_res)
    );

endmodule

>>> hdl/pss_ram.sv
module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/pss_ctrl.sv
module pss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_req_type,
    output logic           o_ready,
    output pss_pkg::t_cmd  o_cmd,
    input  pss_pkg::t_stat i_stat
);

    pss_pkg::t_state r_state;
    pss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pss_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            pss_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (pss_pkg::t_req'(i_req_type))
                        pss_pkg::REQ_NEEDLE: o_cmd.app_needle = 1'b1;
                        pss_pkg::REQ_HAY:    o_cmd.app_hay = 1'b1;
                        pss_pkg::REQ_SEARCH: begin
                            o_cmd.init = 1'b1;
                            if (i_stat.needle_empty) begin
                                n_state = pss_pkg::ST_HIT;
                            end else if (i_stat.hay_empty) begin
                                n_state = pss_pkg::ST_MISS;
                            end else begin
                                n_state = pss_pkg::ST_STEP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            pss_pkg::ST_STEP: begin
                if (i_stat.in_range) begin
                    n_state = pss_pkg::ST_EVAL;
                end else if (i_stat.needle_done) begin
                    n_state = pss_pkg::ST_HIT;
                end else if (i_stat.has_next) begin
                    o_cmd.next_start = 1'b1;
                end else begin
                    n_state = pss_pkg::ST_MISS;
                end
            end
            pss_pkg::ST_EVAL: begin
                if (i_stat.pair_sep) begin
                    o_cmd.skip_enter = 1'b1;
                    n_state = pss_pkg::ST_SKIP_RD;
                end else if (i_stat.pair_eq) begin
                    o_cmd.pair_step = 1'b1;
                    n_state = pss_pkg::ST_STEP;
                end else if (i_stat.has_next) begin
                    o_cmd.next_start = 1'b1;
                    n_state = pss_pkg::ST_STEP;
                end else begin
                    n_state = pss_pkg::ST_MISS;
                end
            end
            pss_pkg::ST_SKIP_RD: begin
                n_state = pss_pkg::ST_SKIP_EV;
            end
            pss_pkg::ST_SKIP_EV: begin
                o_cmd.skip_step = 1'b1;
                n_state = i_stat.skip_more ? pss_pkg::ST_SKIP_RD : pss_pkg::ST_STEP;
            end
            pss_pkg::ST_HIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_hit = 1'b1;
                    n_state = pss_pkg::ST_IDLE;
                end
            end
            pss_pkg::ST_MISS: begin
                if (i_stat.out_free) begin
                    o_cmd.load_miss = 1'b1;
                    n_state = pss_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/pss_dp.sv
module pss_dp #(
    parameter int NEEDLE_DEPTH   = 64,
    parameter int HAYSTACK_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_char_byte,
    input  pss_pkg::t_cmd     i_cmd,
    output pss_pkg::t_stat    o_stat,
    pss_res_if.source         o_res
);

    localparam int NAW = (NEEDLE_DEPTH > 1) ? $clog2(NEEDLE_DEPTH) : 1;
    localparam int NCW = $clog2(NEEDLE_DEPTH + 1);
    localparam int HAW = (HAYSTACK_DEPTH > 1) ? $clog2(HAYSTACK_DEPTH) : 1;
    localparam int HCW = $clog2(HAYSTACK_DEPTH + 1);
    localparam logic [NCW-1:0] N_FULL = NCW'(NEEDLE_DEPTH);
    localparam logic [HCW-1:0] H_FULL = HCW'(HAYSTACK_DEPTH);

    logic [NCW-1:0] r_ncnt;
    logic [HCW-1:0] r_hcnt;
    logic           r_drop;
    logic [HCW-1:0] r_s;
    logic [HCW-1:0] r_h;
    logic [NCW-1:0] r_n;
    logic           r_skip_h;
    logic           r_skip_n;

    logic           r_out_valid;
    logic           r_found;
    pss_pkg::t_off  r_off;
    pss_pkg::t_len  r_len;
    logic           r_ovf;

    pss_pkg::t_byte w_nb;
    pss_pkg::t_byte w_hb;
    logic           w_n_we;
    logic           w_h_we;
    logic [HCW-1:0] w_s_next;
    logic           w_h_in;
    logic           w_n_in;
    logic           w_hs;
    logic           w_ns;

    assign w_n_we = i_cmd.app_needle && (r_ncnt < N_FULL);
    assign w_h_we = i_cmd.app_hay && (r_hcnt < H_FULL);

    pss_ram #(.WIDTH(8), .DEPTH(NEEDLE_DEPTH)) u_needle_ram (
        .i_clk   (i_clk),
        .i_we    (w_n_we),
        .i_waddr (r_ncnt[NAW-1:0]),
        .i_wdata (i_char_byte),
        .i_raddr (r_n[NAW-1:0]),
        .o_rdata (w_nb)
    );

    pss_ram #(.WIDTH(8), .DEPTH(HAYSTACK_DEPTH)) u_hay_ram (
        .i_clk   (i_clk),
        .i_we    (w_h_we),
        .i_waddr (r_hcnt[HAW-1:0]),
        .i_wdata (i_char_byte),
        .i_raddr (r_h[HAW-1:0]),
        .o_rdata (w_hb)
    );

    assign w_s_next = r_s + HCW'(1);
    assign w_h_in   = r_h < r_hcnt;
    assign w_n_in   = r_n < r_ncnt;
    // separator run continues on each side while still inside its store
    assign w_hs     = r_skip_h && w_h_in && pss_pkg::is_sep(w_hb);
    assign w_ns     = r_skip_n && w_n_in && pss_pkg::is_sep(w_nb);

    always_comb begin
        o_stat.needle_empty = (r_ncnt == '0);
        o_stat.hay_empty    = (r_hcnt == '0);
        o_stat.in_range     = w_h_in && w_n_in;
        o_stat.needle_done  = (r_n == r_ncnt);
        o_stat.pair_sep     = pss_pkg::is_sep(w_hb) && pss_pkg::is_sep(w_nb);
        o_stat.pair_eq      = pss_pkg::fold_case(w_hb) == pss_pkg::fold_case(w_nb);
        o_stat.has_next     = w_s_next < r_hcnt;
        o_stat.skip_more    = w_hs || w_ns;
        o_stat.out_free     = !r_out_valid || o_res.ready;
    end

    // store fill counts and drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncnt <= '0;
            r_hcnt <= '0;
            r_drop <= 1'b0;
        end else if (i_cmd.load_hit || i_cmd.load_miss) begin
            r_ncnt <= '0;
            r_hcnt <= '0;
            r_drop <= 1'b0;
        end else begin
            if (w_n_we) begin
                r_ncnt <= r_ncnt + NCW'(1);
            end
            if (w_h_we) begin
                r_hcnt <= r_hcnt + HCW'(1);
            end
            if ((i_cmd.app_needle && !w_n_we) || (i_cmd.app_hay && !w_h_we)) begin
                r_drop <= 1'b1;
            end
        end
    end

    // scan pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s      <= '0;
            r_h      <= '0;
            r_n      <= '0;
            r_skip_h <= 1'b0;
            r_skip_n <= 1'b0;
        end else if (i_cmd.init) begin
            r_s <= '0;
            r_h <= '0;
            r_n <= '0;
        end else if (i_cmd.next_start) begin
            r_s <= w_s_next;
            r_h <= w_s_next;
            r_n <= '0;
        end else if (i_cmd.pair_step) begin
            r_h <= r_h + HCW'(1);
            r_n <= r_n + NCW'(1);
        end else if (i_cmd.skip_enter) begin
            r_h      <= r_h + HCW'(1);
            r_n      <= r_n + NCW'(1);
            r_skip_h <= 1'b1;
            r_skip_n <= 1'b1;
        end else if (i_cmd.skip_step) begin
            r_h      <= r_h + HCW'(w_hs);
            r_n      <= r_n + NCW'(w_ns);
            r_skip_h <= w_hs;
            r_skip_n <= w_ns;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_hit || i_cmd.load_miss) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_hit) begin
            r_found <= 1'b1;
            r_off   <= pss_pkg::t_off'(r_s);
            r_len   <= pss_pkg::t_len'(r_h - r_s);
            r_ovf   <= r_drop;
        end else if (i_cmd.load_miss) begin
            r_found <= 1'b0;
            r_off   <= '0;
            r_len   <= '0;
            r_ovf   <= r_drop;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.found        = r_found;
    assign o_res.match_offset = r_off;
    assign o_res.match_length = r_len;
    assign o_res.overflow     = r_ovf;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ncnt <= N_FULL) && (r_hcnt <= H_FULL))
        else $error("store count beyond depth");

    a_hit_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_hit |-> (r_n == r_ncnt))
        else $error("hit with needle not fully consumed");

    a_hit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_hit && (r_ncnt != '0)) |-> (r_h > r_s))
        else $error("non-empty needle matched zero haystack bytes");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_hit || i_cmd.load_miss) |-> (!r_out_valid || o_res.ready))
        else $error("result loaded over an untaken result");

    a_load_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_hit || i_cmd.load_miss) |=>
            (r_out_valid && (r_ncnt == '0) && (r_hcnt == '0) && !r_drop))
        else $error("stores not cleared after search");

endmodule

>>> dv/search_sb_pkg.sv
`timescale 1ns / 1ps

package search_sb_pkg;

    import pss_pkg::*;

    localparam int NEEDLE_CAP = 64;
    localparam int HAY_CAP    = 256;

    typedef struct packed {
        logic found;
        t_off match_offset;
        t_len match_length;
        logic overflow;
    } t_search_result;

    class search_scoreboard;

        t_byte          needle_mem [NEEDLE_CAP];
        int unsigned    needle_len;
        t_byte          hay_mem [HAY_CAP];
        int unsigned    hay_len;
        bit             dropped;
        t_search_result expected_q [$];
        int unsigned    errors;
        int unsigned    checked;
        int unsigned    hits;
        int unsigned    overflows;

        function new();
            needle_len = 0;
            hay_len    = 0;
            dropped    = 1'b0;
            errors     = 0;
            checked    = 0;
            hits       = 0;
            overflows  = 0;
        endfunction

        function bit path_sep(t_byte b);
            return (b == SEP_SLASH) || (b == SEP_BSLASH);
        endfunction

        // only plain ascii capitals fold, bytes above 127 compare exactly
        function t_byte fold_letter(t_byte b);
            if (b >= CHR_UP_A && b <= CHR_UP_Z) begin
                return b + CASE_BIT;
            end
            return b;
        endfunction

        // a separator run on either side is swallowed whole
        function bit attempt_at(int unsigned start, output int unsigned span);
            int unsigned h;
            int unsigned n;
            h    = start;
            n    = 0;
            span = 0;
            while (h < hay_len && n < needle_len) begin
                if (path_sep(hay_mem[h]) && path_sep(needle_mem[n])) begin
                    while (h < hay_len && path_sep(hay_mem[h])) h++;
                    while (n < needle_len && path_sep(needle_mem[n])) n++;
                end else if (fold_letter(hay_mem[h]) != fold_letter(needle_mem[n])) begin
                    return 1'b0;
                end else begin
                    h++;
                    n++;
                end
            end
            span = h - start;
            return n == needle_len;
        endfunction

        function void predict_search();
            t_search_result want;
            int unsigned    span;
            want          = '0;
            want.overflow = dropped;
            if (needle_len == 0) begin
                want.found = 1'b1;
            end else begin
                for (int unsigned s = 0; s < hay_len; s++) begin
                    if (attempt_at(s, span)) begin
                        want.found        = 1'b1;
                        want.match_offset = t_off'(s);
                        want.match_length = t_len'(span);
                        break;
                    end
                end
            end
            expected_q.push_back(want);
            needle_len = 0;
            hay_len    = 0;
            dropped    = 1'b0;
        endfunction

        function void note_request(logic [1:0] code, t_byte b);
            case (code)
                REQ_NEEDLE: begin
                    if (needle_len < NEEDLE_CAP) begin
                        needle_mem[needle_len] = b;
                        needle_len++;
                    end else begin
                        dropped = 1'b1;
                    end
                end
                REQ_HAY: begin
                    if (hay_len < HAY_CAP) begin
                        hay_mem[hay_len] = b;
                        hay_len++;
                    end else begin
                        dropped = 1'b1;
                    end
                end
                REQ_SEARCH: predict_search();
                default: ;
            endcase
        endfunction

        function void check_result(t_search_result got);
            t_search_result want;
            if (expected_q.size() == 0) begin
                $error("result with no search outstanding: found=%0d offset=%0d %s=%0d ovf=%0d",
                       got.found, got.match_offset, "length", got.match_length,
                       got.overflow);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.found) hits++;
            if (want.overflow) overflows++;
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                errors++;
            end
            if (got.match_offset !== want.match_offset) begin
                $error("match_offset: expected %0d, got %0d",
                       want.match_offset, got.match_offset);
                errors++;
            end
            if (got.match_length !== want.match_length) begin
                $error("match_length: expected %0d, got %0d",
                       want.match_length, got.match_length);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

    import pss_pkg::*;
    import search_sb_pkg::*;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 340;
    localparam int         DRAIN_CYCLES = 50;
    localparam int         QUIET_LIMIT  = 200000;

    logic i_clk;
    logic i_rst_n;

    pss_req_if req_if ();
    pss_res_if res_if ();

    path_substring_search_core #(
        .NEEDLE_DEPTH   (NEEDLE_CAP),
        .HAYSTACK_DEPTH (HAY_CAP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    search_scoreboard sb = new();

    int unsigned burst_left   = 0;
    int unsigned sent_items   = 0;
    int unsigned unused_items = 0;
    int unsigned quiet_cycles = 0;
    int unsigned cyc          = 0;
    int unsigned stall_mode   = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // monitors, result-side stall pattern and watchdog
    always @(posedge i_clk) begin
        t_search_result got;
        logic           took_req;
        logic           took_res;
        cyc++;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            quiet_cycles = 0;
        end else begin
            took_req = req_if.valid && req_if.ready;
            took_res = res_if.valid && res_if.ready;
            if (took_req) begin
                sb.note_request(req_if.req_type, req_if.char_byte);
            end
            if (took_res) begin
                got.found        = res_if.found;
                got.match_offset = res_if.match_offset;
                got.match_length = res_if.match_length;
                got.overflow     = res_if.overflow;
                sb.check_result(got);
            end
            if (cyc % 97 == 0) begin
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= 1'($urandom_range(0, 1));
                2:       res_if.ready <= ($urandom_range(0, 3) == 0);
                default: res_if.ready <= cyc[2];
            endcase
            if (took_req || took_res) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $error("no handshake for %0d cycles, %0d results outstanding",
                       QUIET_LIMIT, sb.pending());
                $display("tb failed");
                $finish;
            end
        end
    end

    // sender works in bursts with random gaps between them
    task automatic send_item(input logic [1:0] code, input t_byte value);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= code;
        req_if.char_byte <= value;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        burst_left--;
        if (code == REQ_UNUSED) begin
            unused_items++;
        end else begin
            sent_items++;
        end
    endtask

    // hold off until every search has been answered
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // needle and haystack bytes interleaved at random, the odd unused code mixed in, then a search
    task automatic load_and_search(input t_byte nq[$], input t_byte hq[$]);
        int unsigned ni;
        int unsigned hi;
        ni = 0;
        hi = 0;
        while (ni < nq.size() || hi < hq.size()) begin
            if ($urandom_range(0, 15) == 0) begin
                send_item(REQ_UNUSED, t_byte'($urandom));
            end else if (hi >= hq.size()
                         || (ni < nq.size() && $urandom_range(0, 1) == 1)) begin
                send_item(REQ_NEEDLE, nq[ni]);
                ni++;
            end else begin
                send_item(REQ_HAY, hq[hi]);
                hi++;
            end
        end
        send_item(REQ_SEARCH, t_byte'($urandom));
    endtask

    // small alphabet so that matches are frequent, plus the bytes either side of the letters
    function automatic t_byte pick_char();
        t_byte border_chars [8];
        border_chars = '{8'h40, 8'h5B, 8'h60, 8'h7B, CHR_UP_Z, CHR_UP_Z + CASE_BIT, 8'hC1, 8'hE1};
        case ($urandom_range(0, 9))
            0, 1, 2: return CHR_UP_A + CASE_BIT + t_byte'($urandom_range(0, 2));
            3, 4:    return CHR_UP_A + t_byte'($urandom_range(0, 2));
            5, 6:    return ($urandom_range(0, 1) == 1) ? SEP_SLASH : SEP_BSLASH;
            7:       return border_chars[$urandom_range(0, 7)];
            default: return t_byte'($urandom);
        endcase
    endfunction

    task automatic run_search_case();
        t_byte       nq [$];
        t_byte       hq [$];
        t_byte       copy_q [$];
        t_byte       b;
        int unsigned i;
        int unsigned pos;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            repeat ($urandom_range(1, 6)) nq.push_back(pick_char());
            repeat ($urandom_range(0, 24)) hq.push_back(pick_char());
            if ($urandom_range(0, 9) < 7) begin
                // plant a copy with letter case and separator runs varied
                i = 0;
                while (i < nq.size()) begin
                    if (sb.path_sep(nq[i])) begin
                        while (i < nq.size() && sb.path_sep(nq[i])) i++;
                        repeat ($urandom_range(1, 3)) begin
                            copy_q.push_back(($urandom_range(0, 1) == 1) ? SEP_SLASH : SEP_BSLASH);
                        end
                    end else begin
                        b = nq[i];
                        if ((b & ~CASE_BIT) >= CHR_UP_A && (b & ~CASE_BIT) <= CHR_UP_Z
                            && $urandom_range(0, 1) == 1) begin
                            b = b ^ CASE_BIT;
                        end
                        copy_q.push_back(b);
                        i++;
                    end
                end
                // near miss now and then
                if ($urandom_range(0, 4) == 0) begin
                    copy_q[copy_q.size() - 1] = pick_char();
                end
                pos = $urandom_range(0, hq.size());
                foreach (copy_q[k]) hq.insert(pos + k, copy_q[k]);
            end
            load_and_search(nq, hq);
        end else if (kind == 7) begin
            repeat ($urandom_range(0, 8)) hq.push_back(pick_char());
            load_and_search(nq, hq);
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 10)) begin
                send_item(2'($urandom_range(0, 3)), t_byte'($urandom));
            end
        end else begin
            // needle with no haystack, then a search on empty stores
            repeat ($urandom_range(1, 4)) nq.push_back(pick_char());
            load_and_search(nq, hq);
            send_item(REQ_SEARCH, t_byte'($urandom));
        end
    endtask

    initial begin
        t_byte       nq [$];
        t_byte       hq [$];
        int unsigned rand_start;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_NEEDLE;
        req_if.char_byte = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty stores, empty needle, empty haystack
        load_and_search(nq, hq);
        hq = {8'h00};
        load_and_search(nq, hq);
        nq = {8'hFF};
        hq.delete();
        load_and_search(nq, hq);
        // unused code, then case folding ("Ab" in "xaB")
        send_item(REQ_UNUSED, 8'hFF);
        nq = {CHR_UP_A, 8'h62};
        hq = {8'h78, 8'h61, 8'h42};
        load_and_search(nq, hq);
        // separator runs of different length and mix
        nq = {8'h61, SEP_SLASH, SEP_BSLASH, 8'h62};
        hq = {CHR_UP_A, SEP_BSLASH, SEP_SLASH, SEP_SLASH, 8'h42};
        load_and_search(nq, hq);
        // needle longer than the haystack
        nq = {8'h61, 8'h62};
        hq = {8'h61};
        load_and_search(nq, hq);
        wait_drained();

        // full stores: needle overflow, then haystack overflow with a separator
        // run over all but the last store entry, ending in a match of full length
        nq.delete();
        hq.delete();
        repeat (NEEDLE_CAP + 2) nq.push_back(pick_char());
        repeat (10) hq.push_back(pick_char());
        load_and_search(nq, hq);
        nq = {SEP_BSLASH, 8'h71};
        hq.delete();
        repeat (HAY_CAP - 1) hq.push_back(SEP_SLASH);
        hq.push_back(8'h51);
        hq.push_back(8'h78);
        hq.push_back(8'h78);
        load_and_search(nq, hq);
        wait_drained();

        rand_start = sent_items;
        while (sent_items - rand_start < RANDOM_ITEMS) begin
            run_search_case();
            if ($urandom_range(0, 19) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d load/search items and %0d unused codes sent", sent_items,
                 unused_items);
        $display("summary: %0d searches checked, %0d found, %0d with dropped bytes",
                 sb.checked, sb.hits, sb.overflows);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/pss_pkg.sv
hdl/pss_ifs.sv
hdl/pss_ram.sv
hdl/pss_ctrl.sv
hdl/pss_dp.sv
hdl/path_substring_search_core.sv
dv/search_sb_pkg.sv
dv/tb.sv
